@@ src/afp_pkg.sv @@
// Shared constants and types for the animation frame picker.
package afp_pkg;

   localparam int MAX_FRAMES_DEF = 64;

   localparam int OP_W      = 1;
   localparam int IDX_W     = 6;
   localparam int DELAY_W   = 16;
   localparam int ELAPSED_W = 32;
   localparam int FRAME_W   = 6;
   localparam int COUNT_W   = 7;

   // A full sum of up to 127 sixteen-bit delays fits in this many bits.
   localparam int SUM_W = DELAY_W + COUNT_W;

   localparam int REQ_DATA_W = ((IDX_W + DELAY_W + ELAPSED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((FRAME_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_PICK = 1'b1;

endpackage

@@ src/afp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module afp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/afp_rem_unit.sv @@
// Bit-serial restoring remainder unit: elapsed time modulo the delay total.
module afp_rem_unit
   import afp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ELAPSED_W-1:0] dividend,
   input  logic [SUM_W-1:0]     divisor,
   output logic                 done,
   output logic [SUM_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(ELAPSED_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ELAPSED_W-1:0] dvd_ff, dvd_in;
   logic [SUM_W-1:0]     dsr_ff, dsr_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W:0]       shifted;
   logic [SUM_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, dvd_ff[ELAPSED_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ELAPSED_W - 1);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one
         // compare and subtract per bit is enough.
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = trial[SUM_W-1:0];
         end else begin
            rem_in = shifted[SUM_W-1:0];
         end
         dvd_in = {dvd_ff[ELAPSED_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ src/animation_frame_picker_top.sv @@
// Animation frame picker: delay table in RAM, sum walk, serial modulo, lookup walk.
// A load gives no result. A pick for N frames in use makes up to two passes of N RAM reads
// plus 32 modulo steps, and makes none of them with fewer than two or over MAX_FRAMES.
// One pick at a time: the input is not ready until the answer has entered the result register.
// Reset sets frames_in_use to 1 and empties the result register; the table is not cleared.
module animation_frame_picker_top
   import afp_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index [5:0], delay_ms [21:6], elapsed_time [53:22], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_index [5:0], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_FRAMES);
   localparam int KX_W   = (ADDR_W > COUNT_W) ? ADDR_W : COUNT_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_WALK = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   frames_ff;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_W-1:0]   issue_k_ff, issue_k_in;
   logic                 issuing_ff, issuing_in;
   logic                 rd_valid_ff;
   logic                 rd_last_ff;
   logic [COUNT_W-1:0]   rd_k_ff;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [COUNT_W-1:0]   res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   // One-cycle pulse into the remainder unit on entering the modulo state.
   logic                 div_start_ff;

   logic [IDX_W-1:0]     req_idx;
   logic [DELAY_W-1:0]   req_delay;
   logic [ELAPSED_W-1:0] req_elapsed;
   logic                 req_fire;
   logic                 idx_ok;
   logic                 count_ok;
   logic [KX_W-1:0]      idx_ext;
   logic [KX_W-1:0]      k_ext;
   logic                 ram_we;
   logic [DELAY_W-1:0]   ram_rdata;
   logic [SUM_W-1:0]     run_sum;
   logic [SUM_W-1:0]     total;
   logic                 rsp_free;
   logic                 div_done;
   logic [SUM_W-1:0]     div_rem;

   assign req_idx     = req_tdata[IDX_W-1:0];
   assign req_delay   = req_tdata[IDX_W+DELAY_W-1:IDX_W];
   assign req_elapsed = req_tdata[IDX_W+DELAY_W+ELAPSED_W-1:IDX_W+DELAY_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign idx_ext  = KX_W'(req_idx);
   assign k_ext    = KX_W'(issue_k_ff);
   assign idx_ok   = 32'(req_idx) < 32'(MAX_FRAMES);
   assign count_ok = (frames_ff > COUNT_W'(1)) && (32'(frames_ff) <= 32'(MAX_FRAMES));
   assign ram_we   = req_fire && (req_tuser == OP_LOAD) && idx_ok;

   afp_ram #(
      .WIDTH(DELAY_W),
      .DEPTH(MAX_FRAMES)
   ) u_delay_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(idx_ext[ADDR_W-1:0]),
      .wr_data(req_delay),
      .rd_en  (issuing_ff),
      .rd_addr(k_ext[ADDR_W-1:0]),
      .rd_data(ram_rdata)
   );

   afp_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (elapsed_ff),
      .divisor  (acc_ff),
      .done     (div_done),
      .remainder(div_rem)
   );

   assign run_sum  = acc_ff + SUM_W'(ram_rdata);
   assign total    = (run_sum == '0) ? SUM_W'(1) : run_sum;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      elapsed_in     = elapsed_ff;
      issue_k_in     = issue_k_ff;
      issuing_in     = issuing_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_frame_in   = rsp_frame_ff;

      // Reads are issued back to back; stop once the last frame in use is issued.
      if (issuing_ff) begin
         issue_k_in = issue_k_ff + 1'b1;
         if (issue_k_ff == frames_ff - 1'b1) begin
            issuing_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == OP_PICK)) begin
               elapsed_in = req_elapsed;
               acc_in     = '0;
               if (count_ok) begin
                  issue_k_in = '0;
                  issuing_in = 1'b1;
                  state_in   = ST_SUM;
               end else begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            if (rd_valid_ff) begin
               acc_in = run_sum;
               if (rd_last_ff) begin
                  acc_in   = total;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // The divisor is taken from the accumulator, which holds the delay total once the sum pass ends.
            if (div_done) begin
               rem_in     = div_rem;
               acc_in     = '0;
               issue_k_in = '0;
               issuing_in = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rd_valid_ff) begin
               acc_in = run_sum;
               if (rem_ff < run_sum) begin
                  res_in     = rd_k_ff;
                  issuing_in = 1'b0;
                  state_in   = ST_DONE;
               end else if (rd_last_ff) begin
                  res_in   = frames_ff - 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = res_ff[FRAME_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= COUNT_W'(1);
         issuing_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         rd_valid_ff  <= issuing_ff;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= (state_ff == ST_SUM) && (state_in == ST_DIV);
         if (csr_we) begin
            frames_ff <= csr_wdata;
         end
      end
      elapsed_ff   <= elapsed_in;
      issue_k_ff   <= issue_k_in;
      rd_last_ff   <= issuing_ff && (issue_k_ff == frames_ff - 1'b1);
      rd_k_ff      <= issue_k_ff;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_frame_ff);

endmodule

@@ test/tb.sv @@
// Testbench for the animation frame picker: stream driver, result monitor and frame predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afp_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [OP_W-1:0]      op;
      logic [IDX_W-1:0]     entry;
      logic [DELAY_W-1:0]   delay;
      logic [ELAPSED_W-1:0] elapsed;
   } cursor_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [COUNT_W-1:0]    csr_wdata = '0;

   // Predictor state, updated as beats are accepted.
   logic [DELAY_W-1:0] frame_delays [MAX_FRAMES_DEF];
   logic [COUNT_W-1:0] active_frames = COUNT_W'(1);
   logic [FRAME_W-1:0] expected_frames [$];

   // Generator view of the table, updated as beats are queued.
   logic [DELAY_W-1:0] plan_delays [MAX_FRAMES_DEF];
   logic               written [MAX_FRAMES_DEF];

   cursor_beat_type beat_queue [$];
   cursor_beat_type offered;
   int unsigned  beats_queued = 0;
   int unsigned  beats_taken = 0;
   int unsigned  cycle_count = 0;
   int           errors = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   int           holds_asked = 0;
   int           holds_done = 0;
   logic         quiet_tail = 1'b0;
   logic [FRAME_W-1:0] want_frame;

   animation_frame_picker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic logic [FRAME_W-1:0] pick_frame(input logic [ELAPSED_W-1:0] elapsed);
      logic [31:0] total;
      logic [31:0] run;
      logic [31:0] rem;
      int          n;
      n = int'(active_frames);
      if (n < 2 || n > MAX_FRAMES_DEF) return '0;
      total = 0;
      for (int k = 0; k < n; k++) total += 32'(frame_delays[k]);
      if (total == 0) total = 1;
      rem = elapsed % total;
      run = 0;
      for (int k = 0; k < n; k++) begin
         run += 32'(frame_delays[k]);
         if (rem < run) return FRAME_W'(k);
      end
      return FRAME_W'(n - 1);
   endfunction

   // Sender: holds a beat until it is taken, with random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            beats_taken++;
            if (offered.op == OP_PICK) begin
               expected_frames.push_back(pick_frame(offered.elapsed));
            end else if (int'(offered.entry) < MAX_FRAMES_DEF) begin
               frame_delays[offered.entry] = offered.delay;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 4) - 1;
            req_tvalid <= 1'b0;
         end else if (beat_queue.size() != 0) begin
            offered = beat_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= offered.op;
            req_tdata <= {{(REQ_DATA_W - IDX_W - DELAY_W - ELAPSED_W){1'b0}},
                          offered.elapsed, offered.delay, offered.entry};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: short random stalls, and one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            errors++;
            $display("%0t: frame_index beat with nothing expected, actual %0d",
                     $time, rsp_tdata[FRAME_W-1:0]);
         end else begin
            want_frame = expected_frames.pop_front();
            if (rsp_tdata[FRAME_W-1:0] !== want_frame) begin
               errors++;
               $display("%0t: frame_index mismatch, expected %0d, actual %0d",
                        $time, want_frame, rsp_tdata[FRAME_W-1:0]);
            end
         end
      end
   end

   function automatic logic [DELAY_W-1:0] rand_delay();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return DELAY_W'($urandom_range(0, 20));
         default: return DELAY_W'($urandom);
      endcase
   endfunction

   // Lands near a cumulative delay boundary, a random number of periods in.
   function automatic logic [ELAPSED_W-1:0] edge_elapsed();
      logic [31:0] total;
      logic [31:0] run;
      int          n;
      int          j;
      n = int'(active_frames);
      if (n < 2 || n > MAX_FRAMES_DEF) return $urandom;
      total = 0;
      for (int k = 0; k < n; k++) total += 32'(plan_delays[k]);
      if (total == 0) total = 1;
      j = $urandom_range(0, n - 1);
      run = 0;
      for (int k = 0; k <= j; k++) run += 32'(plan_delays[k]);
      return total * $urandom_range(0, 4095) + run + $urandom_range(0, 2) - 1;
   endfunction

   task automatic push_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] entry,
                            input logic [DELAY_W-1:0] delay,
                            input logic [ELAPSED_W-1:0] elapsed);
      cursor_beat_type b;
      b.op = op;
      b.entry = entry;
      b.delay = delay;
      b.elapsed = elapsed;
      beat_queue.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_load(input int entry, input logic [DELAY_W-1:0] delay);
      plan_delays[entry] = delay;
      written[entry] = 1'b1;
      push_beat(OP_LOAD, IDX_W'(entry), delay, $urandom);
   endtask

   // A pick must never read an entry that was not loaded since reset.
   task automatic fill_unwritten();
      int n;
      n = int'(active_frames);
      if (n >= 2 && n <= MAX_FRAMES_DEF) begin
         for (int k = 0; k < n; k++) begin
            if (!written[k]) queue_load(k, rand_delay());
         end
      end
   endtask

   task automatic queue_pick_at(input logic [ELAPSED_W-1:0] elapsed);
      fill_unwritten();
      push_beat(OP_PICK, IDX_W'($urandom), DELAY_W'($urandom), elapsed);
   endtask

   task automatic queue_pick();
      logic [ELAPSED_W-1:0] t;
      fill_unwritten();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: t = edge_elapsed();
         4, 5, 6:    t = $urandom;
         7:          t = ELAPSED_W'($urandom_range(0, 300));
         8:          t = '1;
         default:    t = '0;
      endcase
      queue_pick_at(t);
   endtask

   task automatic wait_drained();
      while (beats_taken != beats_queued || expected_frames.size() != 0) @(posedge clock);
   endtask

   // The register is written only once the block has gone idle.
   task automatic set_frame_count(input int n);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= COUNT_W'(n);
      @(posedge clock);
      csr_we <= 1'b0;
      active_frames = COUNT_W'(n);
   endtask

   initial begin
      int n;
      for (int k = 0; k < MAX_FRAMES_DEF; k++) begin
         frame_delays[k] = '0;
         plan_delays[k] = '0;
         written[k] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Static cursor straight out of reset.
      queue_pick_at('0);
      queue_pick_at('1);
      // Frame counts out of range answer frame 0.
      set_frame_count(0);
      queue_pick_at(ELAPSED_W'(5));
      set_frame_count(127);
      queue_pick_at('1);
      set_frame_count(MAX_FRAMES_DEF + 1);
      queue_pick_at('0);
      // All delays zero gives the last frame in use.
      set_frame_count(4);
      for (int k = 0; k < 4; k++) queue_load(k, '0);
      queue_pick_at('0);
      queue_pick_at('1);
      // Extreme delays, with a zero-length frame in between.
      queue_load(0, '1);
      queue_load(1, DELAY_W'(1));
      queue_load(2, '0);
      queue_load(3, '1);
      queue_pick_at(ELAPSED_W'(65534));
      queue_pick_at(ELAPSED_W'(65535));
      queue_pick_at(ELAPSED_W'(65536));
      queue_pick_at('1);
      set_frame_count(MAX_FRAMES_DEF);
      queue_load(MAX_FRAMES_DEF - 1, '1);
      queue_pick_at('1);
      queue_pick_at('0);
      set_frame_count(2);
      queue_pick_at(ELAPSED_W'(65535));
      queue_pick_at(ELAPSED_W'(65536));

      for (int p = 0; p < 12; p++) begin
         case (p)
            0:       n = 2;
            1:       n = MAX_FRAMES_DEF;
            2:       n = 3;
            3:       n = $urandom_range(2, 8);
            4:       n = $urandom_range(9, MAX_FRAMES_DEF - 1);
            5:       n = 1;
            6:       n = 0;
            7:       n = 127;
            8:       n = $urandom_range(MAX_FRAMES_DEF + 1, 126);
            9:       n = $urandom_range(2, 16);
            10:      n = MAX_FRAMES_DEF;
            default: n = $urandom_range(2, MAX_FRAMES_DEF);
         endcase
         set_frame_count(n);
         if (p >= 10) quiet_tail = 1'b1;
         // The result side stops for a long while so that the input backs up.
         if (p == 3) holds_asked++;
         repeat (130) begin
            if ($urandom_range(0, 3) == 0) queue_load($urandom_range(0, MAX_FRAMES_DEF - 1),
                                                      rand_delay());
            else queue_pick();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_frames.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
